@@ hdl/pitt_pkg.sv @@
// Package for the periodic interval timer table.
// Holds the word types, action codes and fixed widths; no dependencies.
package pitt_pkg;

    localparam int DATA_W       = 32;
    localparam int IDX_OUT_W    = 4;
    localparam int RESULT_LIMIT = 16;
    localparam int NFOUND_W     = $clog2(RESULT_LIMIT + 1);

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_SET   = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]        action;
        logic [DATA_W-1:0] period_ticks;
        logic [7:0]        entry_select;
    } t_in_word;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] entry_index;
        logic                 fired;
        logic                 success;
        logic                 last_result;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SET_SCAN,
        ST_TICK_SCAN,
        ST_TICK_READ,
        ST_TICK_DIV,
        ST_TICK_FOUND,
        ST_TICK_FINISH,
        ST_REPLY
    } t_state;

endpackage

@@ hdl/pitt_div.sv @@
// Bit-serial restoring remainder unit, one quotient bit per cycle.
// Depends on pitt_pkg for the data width.
module pitt_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pitt_pkg::DATA_W-1:0] i_dividend,
    input  logic [pitt_pkg::DATA_W-1:0] i_divisor,
    output logic                        o_done,
    output logic                        o_rem_zero
);
    import pitt_pkg::*;

    localparam int STEP_W = $clog2(DATA_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_dvd;
    logic [DATA_W-1:0] r_dvs;

    logic [DATA_W:0]   shifted;
    logic [DATA_W+1:0] diff;
    logic [DATA_W-1:0] n_rem;

    // Shift in the next dividend bit and subtract the divisor if it fits.
    always_comb begin
        shifted = {r_rem, r_dvd[DATA_W-1]};
        diff    = {1'b0, shifted} - {2'b00, r_dvs};
        n_rem   = diff[DATA_W+1] ? shifted[DATA_W-1:0] : diff[DATA_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            // Done pulses for one cycle after the last remainder step.
            r_done <= r_busy && !i_start && (r_step == STEP_W'(DATA_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[DATA_W-2:0], 1'b0};
        end
    end

    assign o_done     = r_done;
    assign o_rem_zero = (r_rem == '0);

endmodule

@@ hdl/periodic_interval_timer_table_unit.sv @@
// Top level of the periodic interval timer table: sequencer, entry memories and output register.
// Depends on pitt_pkg and on pitt_div for the serial remainder.
//
//  Channel  | Handshake                  | Word
//  ---------+----------------------------+------------------------------
//  Input    | i_in_valid / o_in_ready    | i_in_word  (pitt_pkg::t_in_word)
//  Output   | o_out_valid / i_out_ready  | o_out_word (pitt_pkg::t_out_word)
//
// A tick walks the entries one at a time; each live entry waits for the memory read and
// then for the 32-step serial remainder unit. A set scans the free bits one entry per cycle,
// and a clear goes straight from the idle state to the reply state.
// Reset is synchronous and active low; it clears the tick count and all live bits at once,
// so no clearing pass is needed. A stalled output only holds the sequencer when a new word
// must be loaded while the output register is still full.
module periodic_interval_timer_table_unit #(
    parameter int NUM_ENTRIES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  pitt_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output pitt_pkg::t_out_word  o_out_word
);
    import pitt_pkg::*;

    // Index width for the memories and a scan counter that can also hold NUM_ENTRIES.
    localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int CNT_W = $clog2(NUM_ENTRIES + 1);

    t_state r_state, n_state;

    logic [DATA_W-1:0]      r_tick, n_tick;
    logic [NUM_ENTRIES-1:0] r_live, n_live;
    logic [CNT_W-1:0]       r_scan, n_scan;
    logic [NFOUND_W-1:0]    r_nfound, n_nfound;
    logic                   r_pend, n_pend;
    logic [IDX_W-1:0]       r_pend_idx, n_pend_idx;
    logic [DATA_W-1:0]      r_set_period, n_set_period;
    t_out_word              r_reply, n_reply;
    logic                   r_out_valid, n_out_valid;
    t_out_word              r_out_word, n_out_word;

    // Entry memories: one write and one registered read per cycle, same address.
    logic [DATA_W-1:0] r_period_mem [NUM_ENTRIES];
    logic [DATA_W-1:0] r_start_mem  [NUM_ENTRIES];
    logic [DATA_W-1:0] r_rd_period;
    logic [DATA_W-1:0] r_rd_start;
    logic              mem_we;

    logic              in_acc;
    logic              can_load;
    logic              scan_end;
    logic [IDX_W-1:0]  scan_idx;
    logic              scan_live;
    logic [IDX_W-1:0]  sel_idx;
    logic              sel_in_range;
    logic              clr_ok;
    logic [8:0]        scan_idx9;
    logic [8:0]        pend_idx9;
    logic              div_start;
    logic              div_done;
    logic              div_rem_zero;
    logic [DATA_W-1:0] elapsed;

    assign o_in_ready   = (r_state == ST_IDLE);
    assign in_acc       = i_in_valid && o_in_ready;
    assign can_load     = !r_out_valid || i_out_ready;
    assign scan_end     = (r_scan == CNT_W'(NUM_ENTRIES));
    assign scan_idx     = r_scan[IDX_W-1:0];
    assign scan_live    = r_live[scan_idx];
    assign sel_idx      = i_in_word.entry_select[IDX_W-1:0];
    assign sel_in_range = ({1'b0, i_in_word.entry_select} < 9'(NUM_ENTRIES));
    assign clr_ok       = sel_in_range && r_live[sel_idx];
    assign scan_idx9    = 9'(r_scan);
    assign pend_idx9    = 9'(r_pend_idx);
    assign elapsed      = r_tick - r_rd_start;

    pitt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (elapsed),
        .i_divisor  (r_rd_period),
        .o_done     (div_done),
        .o_rem_zero (div_rem_zero)
    );

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_word.action)
                        ACT_TICK:  n_state = ST_TICK_SCAN;
                        ACT_SET:   n_state = ST_SET_SCAN;
                        ACT_CLEAR: n_state = ST_REPLY;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SET_SCAN: begin
                if (scan_end || !scan_live) begin
                    n_state = ST_REPLY;
                end
            end
            ST_TICK_SCAN: begin
                if (scan_end) begin
                    n_state = ST_TICK_FINISH;
                end else if (scan_live) begin
                    n_state = ST_TICK_READ;
                end
            end
            ST_TICK_READ: n_state = ST_TICK_DIV;
            ST_TICK_DIV: begin
                if (div_done) begin
                    n_state = div_rem_zero ? ST_TICK_FOUND : ST_TICK_SCAN;
                end
            end
            ST_TICK_FOUND: begin
                if (!r_pend || can_load) begin
                    if (r_nfound == NFOUND_W'(RESULT_LIMIT - 1)) begin
                        n_state = ST_TICK_FINISH;
                    end else begin
                        n_state = ST_TICK_SCAN;
                    end
                end
            end
            ST_TICK_FINISH: begin
                if (!r_pend || can_load) begin
                    n_state = ST_IDLE;
                end
            end
            ST_REPLY: begin
                if (can_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath control and output register loading for each state.
    always_comb begin
        n_tick       = r_tick;
        n_live       = r_live;
        n_scan       = r_scan;
        n_nfound     = r_nfound;
        n_pend       = r_pend;
        n_pend_idx   = r_pend_idx;
        n_set_period = r_set_period;
        n_reply      = r_reply;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_word   = r_out_word;
        mem_we       = 1'b0;
        div_start    = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_scan       = '0;
                    n_nfound     = '0;
                    n_pend       = 1'b0;
                    n_set_period = i_in_word.period_ticks;
                    unique case (i_in_word.action)
                        ACT_TICK: n_tick = r_tick + 1'b1;
                        ACT_CLEAR: begin
                            if (clr_ok) begin
                                n_live[sel_idx] = 1'b0;
                            end
                            n_reply = '{entry_index: '0, fired: 1'b0,
                                        success: clr_ok, last_result: 1'b1};
                        end
                        default: ;
                    endcase
                end
            end
            ST_SET_SCAN: begin
                if (scan_end) begin
                    n_reply = '{entry_index: '0, fired: 1'b0,
                                success: 1'b0, last_result: 1'b1};
                end else if (!scan_live) begin
                    // A zero period is reported as claimed but leaves the entry free.
                    mem_we           = 1'b1;
                    n_live[scan_idx] = (r_set_period != '0);
                    n_reply = '{entry_index: scan_idx9[IDX_OUT_W-1:0], fired: 1'b0,
                                success: 1'b1, last_result: 1'b1};
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            ST_TICK_SCAN: begin
                if (!scan_end && !scan_live) begin
                    n_scan = r_scan + 1'b1;
                end
            end
            ST_TICK_READ: div_start = 1'b1;
            ST_TICK_DIV: begin
                if (div_done && !div_rem_zero) begin
                    n_scan = r_scan + 1'b1;
                end
            end
            ST_TICK_FOUND: begin
                // The earlier hit goes out now; the new one waits until we know
                // whether anything fires after it.
                if (!r_pend || can_load) begin
                    if (r_pend) begin
                        n_out_valid = 1'b1;
                        n_out_word  = '{entry_index: pend_idx9[IDX_OUT_W-1:0], fired: 1'b1,
                                        success: 1'b0, last_result: 1'b0};
                    end
                    n_pend     = 1'b1;
                    n_pend_idx = scan_idx;
                    n_nfound   = r_nfound + 1'b1;
                    n_scan     = r_scan + 1'b1;
                end
            end
            ST_TICK_FINISH: begin
                if (r_pend && can_load) begin
                    n_out_valid = 1'b1;
                    n_out_word  = '{entry_index: pend_idx9[IDX_OUT_W-1:0], fired: 1'b1,
                                    success: 1'b0, last_result: 1'b1};
                    n_pend      = 1'b0;
                end
            end
            ST_REPLY: begin
                if (can_load) begin
                    n_out_valid = 1'b1;
                    n_out_word  = r_reply;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tick      <= '0;
            r_live      <= '0;
            r_scan      <= '0;
            r_nfound    <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tick      <= n_tick;
            r_live      <= n_live;
            r_scan      <= n_scan;
            r_nfound    <= n_nfound;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx   <= n_pend_idx;
        r_set_period <= n_set_period;
        r_reply      <= n_reply;
        r_out_word   <= n_out_word;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_period_mem[scan_idx] <= r_set_period;
            r_start_mem[scan_idx]  <= r_tick;
        end
        r_rd_period <= r_period_mem[scan_idx];
        r_rd_start  <= r_start_mem[scan_idx];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for periodic_interval_timer_table_unit.
// Depends on pitt_pkg for the word types and action codes, and on the unit itself.
module tb;
    import pitt_pkg::*;

    // The unit has no name for the spare action code; it must be ignored.
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int NUM_SLOTS = 16;
    // A tick over a full table of live entries is the slowest operation of the unit.
    localparam int SETTLE_CYCLES = 800;
    localparam int LONG_HOLD = 1000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in_word = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out_word;

    periodic_interval_timer_table_unit #(
        .NUM_ENTRIES(NUM_SLOTS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Our own copy of the timer state: the tick count and, per entry, the
    // interval (zero means free) and the tick at which the entry was started.
    logic [31:0] tick_now;
    logic [31:0] slot_period [NUM_SLOTS];
    logic [31:0] slot_start  [NUM_SLOTS];

    // Result words still owed by the unit, oldest first.
    t_out_word reply_q [$];

    int errors = 0;

    // Sender and receiver pacing. The maxima are changed per stretch of the
    // run so that some stretches have no idling at all.
    int tx_max_gap = 8;
    int rx_max_stall = 8;
    int rx_wait = 0;
    int rx_hold_left = 0;
    // Written by a test at a falling edge; the receiver takes it over at the
    // next rising edge and counts the hold down itself.
    int rx_hold_req = 0;

    t_out_word got_word;
    t_out_word want_word;

    function automatic void clear_timer_state();
        tick_now = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_period[i] = '0;
            slot_start[i] = '0;
        end
        reply_q.delete();
    endfunction

    // Applies one accepted input word to the timer state and queues the
    // result words it must produce.
    function automatic void timer_table_step(t_in_word w);
        t_out_word r;
        t_out_word held;
        bit have_held;
        bit claimed;
        logic [31:0] age;
        r = '0;
        held = '0;
        have_held = 1'b0;
        claimed = 1'b0;
        case (w.action)
            ACT_TICK: begin
                tick_now = tick_now + 32'd1;
                // Due entries are reported in index order; only the last one
                // carries last_result, so each is held back until the next.
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (slot_period[i] != 32'd0) begin
                        age = tick_now - slot_start[i];
                        if (age % slot_period[i] == 32'd0) begin
                            if (have_held) begin
                                reply_q.push_back(held);
                            end
                            held = '0;
                            held.entry_index = i[3:0];
                            held.fired = 1'b1;
                            have_held = 1'b1;
                        end
                    end
                end
                if (have_held) begin
                    held.last_result = 1'b1;
                    reply_q.push_back(held);
                end
            end
            ACT_SET: begin
                // A zero interval is reported as claimed but leaves the entry free.
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (!claimed && slot_period[i] == 32'd0) begin
                        slot_period[i] = w.period_ticks;
                        slot_start[i] = tick_now;
                        r.entry_index = i[3:0];
                        r.success = 1'b1;
                        claimed = 1'b1;
                    end
                end
                r.last_result = 1'b1;
                reply_q.push_back(r);
            end
            ACT_CLEAR: begin
                if (w.entry_select < NUM_SLOTS) begin
                    if (slot_period[w.entry_select] != 32'd0) begin
                        slot_period[w.entry_select] = '0;
                        slot_start[w.entry_select] = '0;
                        r.success = 1'b1;
                    end
                end
                r.last_result = 1'b1;
                reply_q.push_back(r);
            end
            default: begin
                // Spare action code: no result and no change.
            end
        endcase
    endfunction

    function automatic t_in_word timer_word(logic [1:0] act, logic [31:0] period,
                                            logic [7:0] sel);
        t_in_word w;
        w.action = act;
        w.period_ticks = period;
        w.entry_select = sel;
        return w;
    endfunction

    function automatic void note_error(string what);
        errors++;
        if (errors <= 10) begin
            $display("[%0t] %s", $time, what);
        end
    endfunction

    // Both handshakes are sampled at the rising edge, before any of this
    // edge's nonblocking updates land, so checking and prediction see the
    // same values as the unit does. A result is checked before the input word
    // accepted at the same edge is predicted; that word's results cannot
    // appear before the next edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got_word = o_out_word;
                if (reply_q.size() == 0) begin
                    note_error($sformatf("unexpected result word: idx %0d fired %0b ok %0b last %0b",
                        got_word.entry_index, got_word.fired, got_word.success,
                        got_word.last_result));
                end else begin
                    want_word = reply_q.pop_front();
                    if (got_word.entry_index !== want_word.entry_index
                            || got_word.fired !== want_word.fired
                            || got_word.success !== want_word.success
                            || got_word.last_result !== want_word.last_result) begin
                        note_error($sformatf({"result mismatch: expected idx %0d fired %0b ",
                            "ok %0b last %0b, got idx %0d fired %0b ok %0b last %0b"},
                            want_word.entry_index, want_word.fired, want_word.success,
                            want_word.last_result, got_word.entry_index, got_word.fired,
                            got_word.success, got_word.last_result));
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                timer_table_step(i_in_word);
            end
        end
    end

    // Receiver: after each accepted result word it draws a random stall, up to
    // rx_max_stall. A long hold requested by a test overrides this.
    always @(posedge i_clk) begin
        if (rx_hold_req != 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req = 0;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left = rx_hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                rx_wait = $urandom_range(rx_max_stall, 0);
            end else if (rx_wait != 0) begin
                rx_wait = rx_wait - 1;
            end
            i_out_ready <= (rx_wait == 0);
        end
    end

    // Offers one word after a random gap and returns at the edge where it is
    // accepted. Valid is left high so a following word with no gap goes
    // straight on; valid is only lowered when a gap or a flush comes.
    task automatic send_word(input t_in_word w);
        int gap;
        gap = $urandom_range(tx_max_gap, 0);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // The sender pauses until every owed result word has come back. It always
    // waits for an edge before checking, so valid is never lowered and raised in one step.
    task automatic flush_replies();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (reply_q.size() != 0);
    endtask

    task automatic apply_reset();
        clear_timer_state();
        i_rst_n <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    // Short hand-picked sequence: empty table, rejected clears, a zero
    // interval, extreme intervals, reuse of a freed entry and the spare code.
    task automatic test_directed();
        tx_max_gap = 8;
        rx_max_stall = 8;
        send_word(timer_word(ACT_TICK, 32'd0, 8'd0));
        send_word(timer_word(ACT_UNUSED, 32'hFFFF_FFFF, 8'hFF));
        send_word(timer_word(ACT_CLEAR, 32'd0, 8'd0));
        send_word(timer_word(ACT_CLEAR, 32'd0, 8'd16));
        send_word(timer_word(ACT_CLEAR, 32'hFFFF_FFFF, 8'd255));
        send_word(timer_word(ACT_SET, 32'd0, 8'd0));
        send_word(timer_word(ACT_SET, 32'd1, 8'd0));
        send_word(timer_word(ACT_SET, 32'hFFFF_FFFF, 8'd0));
        send_word(timer_word(ACT_SET, 32'd3, 8'd0));
        send_word(timer_word(ACT_SET, 32'h8000_0000, 8'd0));
        repeat (3) send_word(timer_word(ACT_TICK, 32'hFFFF_FFFF, 8'hFF));
        send_word(timer_word(ACT_CLEAR, 32'd0, 8'd1));
        send_word(timer_word(ACT_CLEAR, 32'd0, 8'd1));
        send_word(timer_word(ACT_SET, 32'd2, 8'd0));
        send_word(timer_word(ACT_TICK, 32'd0, 8'd0));
        send_word(timer_word(ACT_TICK, 32'd0, 8'd0));
        send_word(timer_word(ACT_CLEAR, 32'd0, 8'd0));
        send_word(timer_word(ACT_CLEAR, 32'd0, 8'd2));
        send_word(timer_word(ACT_CLEAR, 32'd0, 8'd3));
        send_word(timer_word(ACT_CLEAR, 32'd0, 8'd1));
        send_word(timer_word(ACT_TICK, 32'd0, 8'd0));
        flush_replies();
    endtask

    // Fills every entry, tries to set on a full table, fires all sixteen at
    // once, then refills the odd entries with short intervals.
    task automatic test_full_table();
        tx_max_gap = 8;
        rx_max_stall = 8;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            send_word(timer_word(ACT_SET, 32'd1, 8'($urandom_range(255, 0))));
        end
        send_word(timer_word(ACT_SET, $urandom(), 8'd0));
        send_word(timer_word(ACT_SET, 32'd0, 8'd0));
        send_word(timer_word(ACT_TICK, $urandom(), 8'($urandom_range(255, 0))));
        for (int i = 1; i < NUM_SLOTS; i += 2) begin
            send_word(timer_word(ACT_CLEAR, $urandom(), 8'(i)));
        end
        for (int i = 1; i < NUM_SLOTS; i += 2) begin
            send_word(timer_word(ACT_SET, 32'($urandom_range(4, 1)), 8'd0));
        end
        repeat (4) send_word(timer_word(ACT_TICK, 32'd0, 8'd0));
        for (int i = 0; i < NUM_SLOTS; i++) begin
            send_word(timer_word(ACT_CLEAR, 32'd0, 8'(i)));
        end
        flush_replies();
    endtask

    // Random mix of ticks, sets and clears. Intervals are mostly short so
    // entries really fire; clears mostly name an in-range entry so they hit
    // live ones. Spare-code words are sprinkled in but not counted.
    task automatic test_random(input int count);
        int done;
        int pick;
        t_in_word w;
        done = 0;
        while (done < count) begin
            if (done % 50 == 0) begin
                tx_max_gap = ($urandom_range(3, 0) == 0) ? 0 : 8;
                rx_max_stall = ($urandom_range(3, 0) == 0) ? 0 : 8;
            end
            w = timer_word(ACT_TICK, $urandom(), 8'($urandom_range(255, 0)));
            pick = $urandom_range(99, 0);
            if (pick < 45) begin
                w.action = ACT_TICK;
            end else if (pick < 70) begin
                w.action = ACT_SET;
                case ($urandom_range(9, 0))
                    0: w.period_ticks = 32'd0;
                    1: w.period_ticks = 32'hFFFF_FFFF;
                    2: w.period_ticks = $urandom();
                    3: w.period_ticks = 32'($urandom_range(64, 1));
                    default: w.period_ticks = 32'($urandom_range(8, 1));
                endcase
            end else if (pick < 93) begin
                w.action = ACT_CLEAR;
                if ($urandom_range(3, 0) != 0) begin
                    w.entry_select = 8'($urandom_range(NUM_SLOTS - 1, 0));
                end
            end else begin
                w.action = ACT_UNUSED;
            end
            send_word(w);
            if (w.action != ACT_UNUSED) begin
                done++;
            end
        end
        flush_replies();
    endtask

    // Every entry fires on every tick; the receiver then holds off for a long
    // stretch while the sender keeps offering ticks with no gaps, so the
    // output backs up into the sequencer and the input stalls.
    task automatic test_backpressure();
        tx_max_gap = 0;
        rx_max_stall = 0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            send_word(timer_word(ACT_CLEAR, 32'd0, 8'(i)));
        end
        for (int i = 0; i < NUM_SLOTS; i++) begin
            send_word(timer_word(ACT_SET, 32'd1, 8'd0));
        end
        flush_replies();
        @(negedge i_clk);
        rx_hold_req = LONG_HOLD;
        @(posedge i_clk);
        repeat (12) send_word(timer_word(ACT_TICK, $urandom(), 8'($urandom_range(255, 0))));
        flush_replies();
        rx_max_stall = 8;
    endtask

    initial begin
        apply_reset();
        test_directed();
        test_full_table();
        test_random(180);
        test_backpressure();
        test_random(170);
        // Ticks that fire nothing may still keep the unit busy after the last
        // result word, so any stray word gets time to show up.
        flush_replies();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0 && reply_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog: this leaves ample time for the slowest correct run before
    // giving up.
    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
